FILE: src/cu128_pkg.sv
// Types and constants shared by the checked 128-bit arithmetic unit.
// No dependencies.
package cu128_pkg;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_MUL64 = 3'd1;
  localparam logic [2:0] OP_MUL128 = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_WMUL = 3'd4;

  // restoring divide: 128 quotient bits, a few per stage
  localparam int DIV_BITS  = 128;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;
  // multiply / add track depth
  localparam int MUL_STAGES = 3;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] a_hi;
    logic [63:0] a_lo;
    logic [63:0] b_hi;
    logic [63:0] b_lo;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    logic [63:0] remainder;
    logic        overflow;
  } out_word_t;

  // one divide pipeline stage: dividend shifts out the top, quotient in the bottom
  typedef struct packed {
    logic         valid;
    logic [2:0]   op;
    logic [127:0] qd;
    logic [63:0]  rem;
    logic [63:0]  d;
  } div_stage_t;

endpackage

FILE: src/cu128_div_stage.sv
// One registered stage of the 128/64 restoring divider, a few bits per stage.
// Depends on cu128_pkg.
module cu128_div_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  cu128_pkg::div_stage_t stage_in,
  output cu128_pkg::div_stage_t stage_out
);

  cu128_pkg::div_stage_t stage_r;
  cu128_pkg::div_stage_t stage_nxt;

  always_comb begin
    logic [64:0]  s;
    logic [127:0] qd;
    logic [63:0]  rem;
    qd  = stage_in.qd;
    rem = stage_in.rem;
    s   = '0;
    for (int i = 0; i < cu128_pkg::DIV_STEPS; i++) begin
      s  = {rem, qd[127]};
      qd = {qd[126:0], 1'b0};
      if (s >= {1'b0, stage_in.d}) begin
        rem   = 64'(s - {1'b0, stage_in.d});
        qd[0] = 1'b1;
      end else begin
        rem = s[63:0];
      end
    end
    stage_nxt       = stage_in;
    stage_nxt.qd    = qd;
    stage_nxt.rem   = rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r.op  <= stage_nxt.op;
      stage_r.qd  <= stage_nxt.qd;
      stage_r.rem <= stage_nxt.rem;
      stage_r.d   <= stage_nxt.d;
    end
  end

  assign stage_out = stage_r;

endmodule

FILE: src/cu128_mul.sv
// Three-stage add / checked multiply track: 32x32 partials, 128-bit products, check.
// Depends on cu128_pkg.
module cu128_mul (
  input  logic                 clk,
  input  logic                 en,
  input  cu128_pkg::in_word_t  in_word,
  output cu128_pkg::out_word_t res
);

  // stage A: partial products
  logic [63:0]  pp_r [12];
  logic [63:0]  pp_nxt [12];
  logic [2:0]   opa_r;
  logic [128:0] sum_r, sum_nxt;
  logic         bothhi_r, bothhi_nxt;
  // stage B: full products
  logic [127:0] p_r [3];
  logic [127:0] p_nxt [3];
  logic [2:0]   opb_r;
  logic [128:0] sumb_r;
  logic         bothhib_r;
  // stage C: result
  cu128_pkg::out_word_t res_r, res_nxt;

  always_comb begin
    logic [63:0] x [3];
    logic [63:0] y [3];
    logic [63:0] bh_eff;
    bh_eff = (in_word.op == cu128_pkg::OP_MUL128) ? in_word.b_hi : 64'd0;
    x[0] = in_word.a_lo; y[0] = in_word.b_lo;
    x[1] = in_word.a_lo; y[1] = bh_eff;
    x[2] = in_word.a_hi; y[2] = in_word.b_lo;
    for (int k = 0; k < 3; k++) begin
      pp_nxt[4*k]   = {32'd0, x[k][31:0]}  * {32'd0, y[k][31:0]};
      pp_nxt[4*k+1] = {32'd0, x[k][31:0]}  * {32'd0, y[k][63:32]};
      pp_nxt[4*k+2] = {32'd0, x[k][63:32]} * {32'd0, y[k][31:0]};
      pp_nxt[4*k+3] = {32'd0, x[k][63:32]} * {32'd0, y[k][63:32]};
    end
    sum_nxt    = {1'b0, in_word.a_hi, in_word.a_lo} + {1'b0, in_word.b_hi, in_word.b_lo};
    bothhi_nxt = (in_word.a_hi != 64'd0) && (bh_eff != 64'd0);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_nxt[k] = {64'd0, pp_r[4*k]} + {32'd0, pp_r[4*k+1], 32'd0}
               + {32'd0, pp_r[4*k+2], 32'd0} + {pp_r[4*k+3], 64'd0};
    end
  end

  always_comb begin
    logic [65:0] mid;
    logic        movf;
    mid  = {2'b0, p_r[0][127:64]} + {2'b0, p_r[1][63:0]} + {2'b0, p_r[2][63:0]};
    movf = bothhib_r || (p_r[1][127:64] != 64'd0) || (p_r[2][127:64] != 64'd0)
         || (mid[65:64] != 2'b0);
    res_nxt = '0;
    case (opb_r)
      cu128_pkg::OP_ADD: begin
        if (sumb_r[128]) res_nxt.overflow = 1'b1;
        else {res_nxt.result_hi, res_nxt.result_lo} = sumb_r[127:0];
      end
      cu128_pkg::OP_MUL64, cu128_pkg::OP_MUL128: begin
        if (movf) res_nxt.overflow = 1'b1;
        else begin
          res_nxt.result_hi = mid[63:0];
          res_nxt.result_lo = p_r[0][63:0];
        end
      end
      cu128_pkg::OP_WMUL: begin
        {res_nxt.result_hi, res_nxt.result_lo} = p_r[0];
      end
      default: res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 12; k++) pp_r[k] <= pp_nxt[k];
      opa_r     <= in_word.op;
      sum_r     <= sum_nxt;
      bothhi_r  <= bothhi_nxt;
      for (int k = 0; k < 3; k++) p_r[k] <= p_nxt[k];
      opb_r     <= opa_r;
      sumb_r    <= sum_r;
      bothhib_r <= bothhi_r;
      res_r     <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: src/checked_uint128_arith_unit.sv
// Top level of the checked 128-bit arithmetic unit.
// Depends on cu128_pkg, cu128_div_stage and cu128_mul.
//
// Usage:
//   Input words (op, a_hi, a_lo, b_hi, b_lo) arrive on in_valid / in_data and
//   are taken at an edge where in_valid is high and in_stall low. Result words
//   (result_hi, result_lo, remainder, overflow) leave on out_valid / out_data
//   and are taken when out_valid is high and out_stall low.
//   Every opcode has the same depth: 32 divider stages of 4 quotient
//   bits each, then the output register. The add and multiply track runs in
//   3 stages beside the divider and its result is delayed to line up.
//   One word per cycle unless stalled; the divider chain sets the depth.
//   The whole pipe moves together: while a result waits with out_stall high
//   every stage holds and in_stall is raised, so nothing is lost or repeated.
//   Empty slots drain freely when the output register is empty.
//   Reset (rst_n low, synchronous) clears the valid bits only; results of
//   overflow are all zero, a zero divisor gives zero quotient and remainder,
//   unused opcodes return an all-zero word.
module checked_uint128_arith_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cu128_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cu128_pkg::out_word_t out_data
);

  localparam int DLY = cu128_pkg::DIV_STAGES - cu128_pkg::MUL_STAGES;

  logic                  en;
  cu128_pkg::div_stage_t div_in;
  cu128_pkg::div_stage_t chain [cu128_pkg::DIV_STAGES];
  cu128_pkg::out_word_t  mul_res;
  cu128_pkg::out_word_t  mdly_r [DLY];
  cu128_pkg::div_stage_t last;
  logic                  out_valid_r;
  cu128_pkg::out_word_t  out_data_r, out_data_nxt;

  // global advance: hold everything while a finished word waits
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign div_in = '{valid: in_valid, op: in_data.op, qd: {in_data.a_hi, in_data.a_lo},
                    rem: 64'd0, d: in_data.b_lo};

  for (genvar g = 0; g < cu128_pkg::DIV_STAGES; g++) begin : g_div
    if (g == 0) begin : g_first
      cu128_div_stage u_stage (
        .clk(clk), .rst_n(rst_n), .en(en), .stage_in(div_in), .stage_out(chain[g])
      );
    end else begin : g_rest
      cu128_div_stage u_stage (
        .clk(clk), .rst_n(rst_n), .en(en), .stage_in(chain[g-1]), .stage_out(chain[g])
      );
    end
  end

  cu128_mul u_mul (
    .clk(clk), .en(en), .in_word(in_data), .res(mul_res)
  );

  // align the multiply track with the divider
  always_ff @(posedge clk) begin
    if (en) begin
      mdly_r[0] <= mul_res;
      for (int k = 1; k < DLY; k++) mdly_r[k] <= mdly_r[k-1];
    end
  end

  assign last = chain[cu128_pkg::DIV_STAGES-1];

  always_comb begin
    out_data_nxt = mdly_r[DLY-1];
    if (last.op == cu128_pkg::OP_DIV) begin
      out_data_nxt = '0;
      if (last.d != 64'd0) begin
        out_data_nxt.result_hi = last.qd[127:64];
        out_data_nxt.result_lo = last.qd[63:0];
        out_data_nxt.remainder = last.rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: dv/tb_checked_uint128_arith_unit.sv
// Self-checking testbench for checked_uint128_arith_unit.
// Depends on cu128_pkg and the unit's RTL; predicts each result word in the bench.
module tb_checked_uint128_arith_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // opcodes the unit leaves unused; they still return one all-zero word
  localparam logic [2:0] OP_SPARE0 = 3'd5;
  localparam logic [2:0] OP_SPARE1 = 3'd6;
  localparam logic [2:0] OP_SPARE2 = 3'd7;
  localparam int PIPE_DEPTH = 33;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  cu128_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  cu128_pkg::out_word_t out_data;

  checked_uint128_arith_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // newest prediction at the front, oldest at the back
  cu128_pkg::out_word_t pending_results[$];
  int        mismatches = 0;
  int        send_idle_pct = 0;  // chance of a gap before each word
  int        stall_pct = 0;      // chance of out_stall in each cycle

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous fixed time, sized for the slowest phases (86% idle)
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Predictor: plain wide arithmetic, no reuse of the RTL's partial products.
  function automatic cu128_pkg::out_word_t arith_predict(cu128_pkg::in_word_t w);
    cu128_pkg::out_word_t r;
    logic [255:0] wide;
    logic [127:0] a;
    logic [127:0] b;
    r = '0;
    a = {w.a_hi, w.a_lo};
    b = {w.b_hi, w.b_lo};
    case (w.op)
      cu128_pkg::OP_ADD: wide = {128'd0, a} + {128'd0, b};
      cu128_pkg::OP_MUL64: wide = {128'd0, a} * {192'd0, w.b_lo};
      cu128_pkg::OP_MUL128: wide = {128'd0, a} * {128'd0, b};
      cu128_pkg::OP_DIV: begin
        wide = '0;
        if (w.b_lo != 0) begin
          {r.result_hi, r.result_lo} = a / {64'd0, w.b_lo};
          r.remainder = 64'(a % {64'd0, w.b_lo});
        end
      end
      cu128_pkg::OP_WMUL: wide = {192'd0, w.a_lo} * {192'd0, w.b_lo};
      default: wide = '0;
    endcase
    if (w.op != cu128_pkg::OP_DIV) begin
      if (wide[255:128] != 0) r.overflow = 1'b1;
      else {r.result_hi, r.result_lo} = wide[127:0];
    end
    return r;
  endfunction

  // one word per call; gap first, then hold valid until accepted
  task automatic send_word(cu128_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    pending_results.push_front(arith_predict(w));
    do @(posedge clk); while (in_stall);
  endtask

  // receiver stall pattern, redrawn each edge
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // checker: every accepted result word against the oldest prediction
  always @(posedge clk) begin
    cu128_pkg::out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        exp_w = pending_results.pop_back();
        if (out_data.result_hi !== exp_w.result_hi || out_data.result_lo !== exp_w.result_lo
            || out_data.remainder !== exp_w.remainder
            || out_data.overflow !== exp_w.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hi %h lo %h rem %h ovf %b / got hi %h lo %h rem %h ovf %b",
                     exp_w.result_hi, exp_w.result_lo, exp_w.remainder, exp_w.overflow,
                     out_data.result_hi, out_data.result_lo, out_data.remainder,
                     out_data.overflow);
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      2: v = 64'd1;
      3: v = v >> $urandom_range(63);   // short values for non-overflowing products
      default: ;
    endcase
    return v;
  endfunction

  function automatic cu128_pkg::in_word_t make_word(logic [2:0] op, logic [63:0] ah,
                                                    logic [63:0] al, logic [63:0] bh,
                                                    logic [63:0] bl);
    cu128_pkg::in_word_t w;
    w.op = op; w.a_hi = ah; w.a_lo = al; w.b_hi = bh; w.b_lo = bl;
    return w;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // extremes, every opcode, overflow edges, zero divisor, unused opcodes
  task automatic test_directed();
    localparam logic [63:0] ONES = '1;
    send_word(make_word(cu128_pkg::OP_ADD, ONES, ONES, 0, 1));      // carry out of top: overflow
    send_word(make_word(cu128_pkg::OP_ADD, ONES, ONES, 0, 0));      // largest exact sum
    send_word(make_word(cu128_pkg::OP_ADD, 0, ONES, 0, 1));         // carry into high half
    send_word(make_word(cu128_pkg::OP_MUL64, ONES, ONES, ONES, 1)); // times one, b_hi ignored
    send_word(make_word(cu128_pkg::OP_MUL64, ONES, ONES, 0, 2));    // overflow
    send_word(make_word(cu128_pkg::OP_MUL64, ONES, ONES, 0, 0));    // zero operand
    send_word(make_word(cu128_pkg::OP_MUL128, 1, 0, 1, 0));         // both high halves set
    send_word(make_word(cu128_pkg::OP_MUL128, 0, ONES, 0, ONES));   // fits exactly
    send_word(make_word(cu128_pkg::OP_MUL128, 0, 0, ONES, ONES));   // zero operand
    send_word(make_word(cu128_pkg::OP_MUL128, 0, 64'h1_0000_0000,
                        64'h1_0000_0000, 0));                        // overflow
    send_word(make_word(cu128_pkg::OP_DIV, ONES, ONES, ONES, 0));   // zero divisor
    send_word(make_word(cu128_pkg::OP_DIV, ONES, ONES, 0, ONES));
    send_word(make_word(cu128_pkg::OP_DIV, ONES, ONES, 0, 1));
    send_word(make_word(cu128_pkg::OP_DIV, 0, 5, 0, 7));            // quotient zero
    send_word(make_word(cu128_pkg::OP_DIV, ONES, 0, 0,
                        64'h8000_0000_0000_0001));                   // divisor top bit set
    send_word(make_word(cu128_pkg::OP_WMUL, ONES, ONES, ONES, ONES));
    send_word(make_word(cu128_pkg::OP_WMUL, ONES, 0, 0, ONES));
    send_word(make_word(OP_SPARE0, ONES, ONES, ONES, ONES));
    send_word(make_word(OP_SPARE1, ONES, ONES, ONES, ONES));
    send_word(make_word(OP_SPARE2, 1, 2, 3, 4));
    wait_drained();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_p);
    logic [2:0] op;
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      send_word(make_word(op, rand64(), rand64(), rand64(), rand64()));
    end
  endtask

  // sender holds off until the pipe has delivered everything, then a burst
  task automatic test_drain_pause();
    send_idle_pct = 0;
    stall_pct = 40;
    test_random(40, 0, 40);
    wait_drained();
    test_random(40, 0, 0);
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(350, 0, 0);     // back to back, no stalls
    test_random(250, 86, 0);    // sparse sender
    test_random(250, 0, 86);    // heavy back-pressure
    test_random(250, 26, 26);   // both sides ragged
    test_drain_pause();
    test_random(100, 0, 0);

    stall_pct = 0;
    wait_drained();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
